>>> hdl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int DEPTH      = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SCROLL_LEN = (ROWS - 1) * COLUMNS;
    localparam int PROMPT_LEN = 2;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'd36;

    typedef enum logic [1:0] {
        REQ_PUT  = 2'd0,
        REQ_READ = 2'd1,
        REQ_INIT = 2'd2
    } req_code_t;

    typedef enum logic {
        REG_TEXT_COLOR   = 1'b0,
        REG_PROMPT_COLOR = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_PROMPT,
        ST_INIT,
        ST_DONE
    } core_state_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_column;
    } req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] text_color;
        logic [COLOR_W-1:0] prompt_color;
    } cfg_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_entry;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
    } rsp_t;

    function automatic logic [CELL_W-1:0] prompt_cell(
        input logic [COL_W-1:0] col,
        input cfg_t             cfg
    );
        logic [CELL_W-1:0] entry;
        if (col == COL_W'(0)) begin
            entry = {cfg.prompt_color, CH_DOLLAR};
        end else if (col == COL_W'(1)) begin
            entry = {cfg.prompt_color, CH_BLANK};
        end else begin
            entry = {cfg.text_color, CH_BLANK};
        end
        return entry;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tcw_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_core
    import tcw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire req_t req_in,
    input  wire cfg_t cfg,
    output logic      in_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    core_state_t       state_reg, state_next;
    req_t              req_reg, req_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CELL_W-1:0] entry_reg, entry_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]  swp_col_reg, swp_col_next;
    logic              pend_reg, pend_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;

    logic              is_newline;
    logic              wrap;
    logic              goes_down;
    logic              last_row;
    logic              rd_in_range;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] addr_cur;
    logic [ADDR_W-1:0] addr_rd;
    logic              sweep_end;

    always_comb begin
        is_newline  = (req_reg.char_code == CH_NEWLINE) || (req_reg.char_code == CH_RETURN);
        wrap        = (col_reg == COL_W'(COLUMNS - 1));
        goes_down   = is_newline || wrap;
        last_row    = (row_reg == ROW_W'(ROWS - 1));
        rd_in_range = (req_reg.cell_row < ROW_W'(ROWS))
                   && (req_reg.cell_column < COL_W'(COLUMNS));
        row_base    = ADDR_W'(row_reg) * ADDR_W'(COLUMNS);
        addr_cur    = row_base + ADDR_W'(col_reg);
        addr_rd     = ADDR_W'(req_reg.cell_row) * ADDR_W'(COLUMNS)
                    + ADDR_W'(req_reg.cell_column);
        sweep_end   = (swp_col_reg == COL_W'(COLUMNS - 1));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (req_reg.req_type)
                    REQ_PUT: begin
                        if (goes_down) begin
                            state_next = last_row ? ST_SCROLL : ST_PROMPT;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    REQ_READ: state_next = rd_in_range ? ST_READ : ST_DONE;
                    REQ_INIT: state_next = ST_INIT;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_READ: state_next = ST_DONE;
            ST_SCROLL: begin
                if (cnt_reg == ADDR_W'(SCROLL_LEN)) begin
                    state_next = ST_PROMPT;
                end
            end
            ST_PROMPT: begin
                if (sweep_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_INIT: begin
                if (cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        req_next     = req_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        entry_next   = entry_reg;
        cnt_next     = cnt_reg;
        swp_col_next = swp_col_reg;
        pend_next    = pend_reg;
        we           = 1'b0;
        waddr        = cnt_reg;
        wdata        = '0;
        raddr        = cnt_reg + ADDR_W'(COLUMNS);
        in_ready     = 1'b0;
        rsp_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (start) begin
                    req_next = req_in;
                end
            end
            ST_EXEC: begin
                entry_next = '0;
                case (req_reg.req_type)
                    REQ_PUT: begin
                        if (!is_newline) begin
                            we       = 1'b1;
                            waddr    = addr_cur;
                            wdata    = {cfg.text_color, req_reg.char_code};
                            col_next = col_reg + COL_W'(1);
                        end
                        if (goes_down) begin
                            col_next     = '0;
                            swp_col_next = '0;
                            pend_next    = 1'b0;
                            if (last_row) begin
                                cnt_next = '0;
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                                cnt_next = row_base + ADDR_W'(COLUMNS);
                            end
                        end
                    end
                    REQ_READ: begin
                        raddr = addr_rd;
                    end
                    REQ_INIT: begin
                        cnt_next     = '0;
                        swp_col_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ: begin
                entry_next = rdata_reg;
            end
            ST_SCROLL: begin
                we    = pend_reg;
                waddr = cnt_reg - ADDR_W'(1);
                wdata = rdata_reg;
                if (cnt_reg == ADDR_W'(SCROLL_LEN)) begin
                    row_next     = ROW_W'(ROWS - 1);
                    swp_col_next = '0;
                end else begin
                    cnt_next  = cnt_reg + ADDR_W'(1);
                    pend_next = 1'b1;
                end
            end
            ST_PROMPT: begin
                we           = 1'b1;
                wdata        = prompt_cell(swp_col_reg, cfg);
                cnt_next     = cnt_reg + ADDR_W'(1);
                swp_col_next = swp_col_reg + COL_W'(1);
                if (sweep_end) begin
                    col_next = COL_W'(PROMPT_LEN);
                end
            end
            ST_INIT: begin
                if (cnt_reg < ADDR_W'(COLUMNS)) begin
                    we    = (row_reg == '0);
                    wdata = prompt_cell(swp_col_reg, cfg);
                end else begin
                    we    = 1'b1;
                    wdata = {cfg.text_color, CH_BLANK};
                end
                cnt_next     = cnt_reg + ADDR_W'(1);
                swp_col_next = sweep_end ? '0 : swp_col_reg + COL_W'(1);
                if (cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    col_next = COL_W'(PROMPT_LEN);
                end
            end
            ST_DONE: begin
                rsp_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rsp.cell_entry    = entry_reg;
        rsp.cursor_row    = row_reg;
        rsp.cursor_column = col_reg;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        entry_reg   <= entry_next;
        cnt_reg     <= cnt_next;
        swp_col_reg <= swp_col_next;
    end

endmodule

`default_nettype wire

>>> hdl/text_console_writer_top.sv
// The block takes one request at a time; the next is taken in the cycle after the result moves to
// the output register. Reset (aresetn low, synchronous) clears the cursor, the control state and
// the output valid and loads the colours with 7 and 4; the screen memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [COLOR_W-1:0] cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [CHAR_W-1:0]  s_char_code,
    input  wire logic [ROW_W-1:0]   s_cell_row,
    input  wire logic [COL_W-1:0]   s_cell_column,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CELL_W-1:0]       m_cell_entry,
    output logic [ROW_W-1:0]        m_cursor_row,
    output logic [COL_W-1:0]        m_cursor_column
);

    cfg_t cfg_reg, cfg_next;
    logic m_valid_reg, m_valid_next;
    rsp_t out_reg, out_next;

    req_t req_in;
    rsp_t rsp;
    logic core_ready;
    logic rsp_valid;
    logic rsp_ready;
    logic start;

    always_comb begin
        req_in.req_type    = s_req_type;
        req_in.char_code   = s_char_code;
        req_in.cell_row    = s_cell_row;
        req_in.cell_column = s_cell_column;
        s_ready            = core_ready;
        start              = s_valid && core_ready;
    end

    tcw_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req_in    (req_in),
        .cfg       (cfg_reg),
        .in_ready  (core_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_TEXT_COLOR:   cfg_next.text_color   = cfg_data;
                REG_PROMPT_COLOR: cfg_next.prompt_color = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rsp_ready    = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (rsp_ready) begin
            m_valid_next = rsp_valid;
            if (rsp_valid) begin
                out_next = rsp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.text_color   <= 8'd7;
            cfg_reg.prompt_color <= 8'd4;
            m_valid_reg          <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_comb begin
        m_valid         = m_valid_reg;
        m_cell_entry    = out_reg.cell_entry;
        m_cursor_row    = out_reg.cursor_row;
        m_cursor_column = out_reg.cursor_column;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while the core was still busy");

    a_cursor_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_column < COL_W'(COLUMNS)))
        else $error("cursor column beyond the screen width");

    a_cursor_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_row < ROW_W'(ROWS)))
        else $error("cursor row beyond the screen height");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("finished result dropped before the output register took it");

endmodule

`default_nettype wire

>>> bench/tb_text_console_writer_top.sv
`timescale 1ns / 1ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         CYCLE_LIMIT = 5_000_000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [COLOR_W-1:0] cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = '0;
    logic [CHAR_W-1:0]  s_char_code = '0;
    logic [ROW_W-1:0]   s_cell_row = '0;
    logic [COL_W-1:0]   s_cell_column = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CELL_W-1:0]  m_cell_entry;
    logic [ROW_W-1:0]   m_cursor_row;
    logic [COL_W-1:0]   m_cursor_column;

    text_console_writer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_char_code     (s_char_code),
        .s_cell_row      (s_cell_row),
        .s_cell_column   (s_cell_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_entry    (m_cell_entry),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_column (m_cursor_column)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the screen, the cursor and the colour registers.
    logic [CELL_W-1:0]  scr_cells [0:DEPTH-1];
    int                 cur_row = 0;
    int                 cur_col = 0;
    logic [COLOR_W-1:0] txt_attr = 8'd7;
    logic [COLOR_W-1:0] prm_attr = 8'd4;

    req_t pending_requests [$];
    rsp_t awaited_replies [$];

    int  errors = 0;
    int  cycle_cnt = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_go = 1'b0;
    logic hold_off = 1'b0;
    int  n_puts = 0;
    int  n_reads = 0;
    int  n_inits = 0;
    int  n_ignored = 0;
    int  n_scrolls = 0;
    int  n_settings = 1;

    function automatic void put_cell(int row, int col, logic [CELL_W-1:0] v);
        if (row < ROWS && col < COLUMNS) begin
            scr_cells[row * COLUMNS + col] = v;
        end
    endfunction

    function automatic void draw_prompt_row();
        put_cell(cur_row, 0, {prm_attr, CH_DOLLAR});
        put_cell(cur_row, 1, {prm_attr, CH_BLANK});
        for (int c = PROMPT_LEN; c < COLUMNS; c++) begin
            put_cell(cur_row, c, {txt_attr, CH_BLANK});
        end
        cur_col = PROMPT_LEN;
    endfunction

    function automatic void advance_row();
        if (cur_row + 1 >= ROWS) begin
            for (int i = 0; i < SCROLL_LEN; i++) begin
                scr_cells[i] = scr_cells[i + COLUMNS];
            end
            cur_row = ROWS - 1;
            n_scrolls++;
        end else begin
            cur_row++;
        end
        draw_prompt_row();
    endfunction

    function automatic rsp_t console_apply(logic [1:0] rt, logic [CHAR_W-1:0] ch,
                                           logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        rsp_t r;
        r = '0;
        case (rt)
            REQ_PUT: begin
                n_puts++;
                if (ch == CH_NEWLINE || ch == CH_RETURN) begin
                    advance_row();
                end else begin
                    put_cell(cur_row, cur_col, {txt_attr, ch});
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        advance_row();
                    end
                end
            end
            REQ_READ: begin
                n_reads++;
                if (rr < ROWS && rc < COLUMNS) begin
                    r.cell_entry = scr_cells[int'(rr) * COLUMNS + int'(rc)];
                end
            end
            REQ_INIT: begin
                n_inits++;
                draw_prompt_row();
                for (int row = 1; row < ROWS; row++) begin
                    for (int c = 0; c < COLUMNS; c++) begin
                        put_cell(row, c, {txt_attr, CH_BLANK});
                    end
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
        r.cursor_row    = ROW_W'(cur_row);
        r.cursor_column = COL_W'(cur_col);
        return r;
    endfunction

    // Sender: offers queued requests and predicts each one as it is accepted.
    always @(posedge aclk) begin
        req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_replies.push_back(
                    console_apply(s_req_type, s_char_code, s_cell_row, s_cell_column));
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    s_valid       <= 1'b1;
                    s_req_type    <= nxt.req_type;
                    s_char_code   <= nxt.char_code;
                    s_cell_row    <= nxt.cell_row;
                    s_cell_column <= nxt.cell_column;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every reply against the oldest prediction.
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply with no request outstanding: entry %h row %0d col %0d",
                           m_cell_entry, m_cursor_row, m_cursor_column);
                    errors++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_cell_entry !== want.cell_entry) begin
                        $error("cell_entry: expected %h, actual %h",
                               want.cell_entry, m_cell_entry);
                        errors++;
                    end
                    if (m_cursor_row !== want.cursor_row) begin
                        $error("cursor_row: expected %0d, actual %0d",
                               want.cursor_row, m_cursor_row);
                        errors++;
                    end
                    if (m_cursor_column !== want.cursor_column) begin
                        $error("cursor_column: expected %0d, actual %0d",
                               want.cursor_column, m_cursor_column);
                        errors++;
                    end
                end
            end
            m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // A long receiver hold-off so that the block backs up and stalls its input.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timed out after %0d cycles with %0d replies outstanding",
                 cycle_cnt, awaited_replies.size());
        $display("tb_text_console_writer_top: FAIL");
        $finish;
    end

    task automatic add_request(logic [1:0] rt, logic [CHAR_W-1:0] ch,
                               logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        req_t q;
        q.req_type    = rt;
        q.char_code   = ch;
        q.cell_row    = rr;
        q.cell_column = rc;
        pending_requests.push_back(q);
    endtask

    function automatic logic [CHAR_W-1:0] rand_glyph();
        logic [CHAR_W-1:0] ch;
        do begin
            ch = CHAR_W'($urandom_range(255));
        end while (ch == CH_NEWLINE || ch == CH_RETURN);
        return ch;
    endfunction

    task automatic add_put(logic [CHAR_W-1:0] ch);
        add_request(REQ_PUT, ch, ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
    endtask

    task automatic add_read(int row, int col);
        add_request(REQ_READ, CHAR_W'($urandom_range(255)), ROW_W'(row), COL_W'(col));
    endtask

    task automatic add_glyph_run(int len);
        repeat (len) add_put(rand_glyph());
    endtask

    function automatic logic [CHAR_W-1:0] rand_newline();
        return $urandom_range(1) ? CH_NEWLINE : CH_RETURN;
    endfunction

    // Mostly runs of text with line breaks and reads in between; some stray requests.
    task automatic add_traffic(int n);
        int added;
        int kind;
        int len;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 12);
                if (len > n - added) begin
                    len = n - added;
                end
                add_glyph_run(len);
                added += len;
                if (added < n && $urandom_range(1)) begin
                    add_put(rand_newline());
                    added++;
                end
            end else if (kind < 80) begin
                add_read($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1));
                added++;
            end else if (kind < 88) begin
                add_put(rand_newline());
                added++;
            end else if (kind < 91) begin
                add_request(REQ_INIT, CHAR_W'($urandom_range(255)),
                            ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
                added++;
            end else if (kind < 95) begin
                add_request(REQ_UNUSED, CHAR_W'($urandom_range(255)),
                            ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
                added++;
            end else begin
                add_read($urandom_range(31), $urandom_range(127));
                added++;
            end
        end
    endtask

    task automatic write_reg(reg_index_t idx, logic [COLOR_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_TEXT_COLOR) begin
            txt_attr = val;
        end else begin
            prm_attr = val;
        end
    endtask

    task automatic set_colours(logic [COLOR_W-1:0] txt, logic [COLOR_W-1:0] prm);
        write_reg(REG_TEXT_COLOR, txt);
        write_reg(REG_PROMPT_COLOR, prm);
        n_settings++;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_valid || awaited_replies.size() > 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Short directed part with the reset colours. The screen is initialised first so
        // that no read ever touches a cell that was never written.
        add_request(REQ_INIT, 8'h00, 5'd0, 7'd0);
        add_read(0, 0);
        add_read(0, 1);
        add_read(ROWS - 1, COLUMNS - 1);
        add_put(8'h41);
        add_put(8'h00);
        add_put(8'hFF);
        add_read(0, 2);
        add_read(0, 4);
        add_read(0, 5);
        add_put(CH_NEWLINE);
        add_read(1, 0);
        add_put(CH_RETURN);
        add_read(2, 1);
        add_read(ROWS, 0);
        add_read(31, 127);
        add_read(0, COLUMNS);
        add_read(0, 127);
        add_request(REQ_UNUSED, 8'hFF, 5'd31, 7'd127);
        add_request(REQ_UNUSED, 8'h00, 5'd0, 7'd0);
        add_read(2, 2);
        wait_drained();

        // Extreme colours; walk to the bottom row, then wrap a full row there to scroll.
        set_colours(8'h00, 8'hFF);
        repeat (ROWS) add_put(rand_newline());
        add_read(ROWS - 1, 0);
        add_read(ROWS - 2, 1);
        add_glyph_run(COLUMNS);
        add_read(ROWS - 2, COLUMNS - 1);
        add_read(ROWS - 1, 0);
        add_read(ROWS - 1, 2);
        add_traffic(20);
        wait_drained();

        // Initialise with the cursor away from the top row, sender idling.
        set_colours(8'hFF, 8'h00);
        send_idle_pct = 60;
        add_put(CH_NEWLINE);
        add_request(REQ_INIT, 8'h5A, 5'd17, 7'd33);
        add_read(ROWS - 1, 0);
        add_read(0, 0);
        add_traffic(30);
        wait_drained();

        set_colours(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)));
        send_idle_pct = 0;
        recv_stall_pct = 60;
        add_traffic(30);
        wait_drained();

        set_colours(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)));
        send_idle_pct = 36;
        recv_stall_pct = 36;
        add_traffic(30);
        wait_drained();

        // Back-pressure: the receiver holds off while short requests keep coming.
        set_colours(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b1;
        add_glyph_run(40);
        add_traffic(10);
        wait_drained();
        repeat (10) @(posedge aclk);

        if (awaited_replies.size() != 0) begin
            $error("%0d replies never arrived", awaited_replies.size());
            errors++;
        end
        $display("Run covered %0d puts, %0d reads, %0d initialisations and %0d ignored requests,",
                 n_puts, n_reads, n_inits, n_ignored);
        $display("with %0d scrolls under %0d colour settings in %0d cycles; %0d errors.",
                 n_scrolls, n_settings, cycle_cnt, errors);
        if (errors == 0) begin
            $display("tb_text_console_writer_top: PASS");
        end else begin
            $display("tb_text_console_writer_top: FAIL");
        end
        $finish;
    end

endmodule
